/* rtl/indexed_position_list_assert.svh */
// assertion macros for the rtl of the indexed position list
// no dependencies; taken in by `include where checks are written
`ifndef INDEXED_POSITION_LIST_ASSERT_SVH
`define INDEXED_POSITION_LIST_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define IPL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define IPL_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* rtl/ipl_pkg.sv */
// shared types and constants for the indexed position list
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ipl_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int OP_W        = 3;
  localparam int POS_W       = 7;
  localparam int COORD_W     = 32;
  localparam int COUNT_W     = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_READ    = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_REPLACE = 3'd3,
    OP_CLEAR   = 3'd4
  } ipl_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PRIME,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } ipl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch the incoming word
    logic setup;       // first memory read and pointer set-up
    logic step;        // one entry moved
    logic write_item;  // store the new coordinate at the position
    logic res_load;    // load the result register and update the count
  } ipl_cmd_t;

  // datapath to controller
  typedef struct packed {
    ipl_op_t op;
    logic    ok;
    logic    shift_needed;
    logic    shift_last;
    logic    out_free;
  } ipl_status_t;

endpackage

`default_nettype wire

/* rtl/indexed_position_list.sv */
// top level of the indexed position list: stream ports, word packing,
// controller and datapath; depends on ipl_pkg, ipl_controller, ipl_datapath
//
//   channel   direction  tdata                               tuser
//   in_*      slave      position[6:0], coord_in[38:7]      opcode[2:0]
//   out_*     master     coord_out[31:0], count[38:32]      ok[0]
//
// one word in, one word out; an op passes through the decode and done states,
// and an insert or remove that moves entries adds a prime state and one shift
// step per entry moved, set by the entry memory moving one entry a cycle
// read, replace and clear never move entries
// rst_n clears the count and the state; entry memory is not cleared
// a new word is taken while the previous result still waits on out_tready;
// the result register stalls the sequencer only when it is still full
`timescale 1ns / 1ps
`default_nettype none

module indexed_position_list import ipl_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // position[6:0], coord_in[38:7], zero pad
  input  wire logic [OP_W-1:0]        in_tuser,   // opcode[2:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // coord_out[31:0], count[38:32], zero pad
  output logic                        out_tuser   // ok
);

  ipl_cmd_t           cmd;
  ipl_status_t        status;
  logic               res_ok;
  logic [COORD_W-1:0] res_coord;
  logic [COUNT_W-1:0] res_count;

  // sequencer: one op at a time
  ipl_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // entry store, count and result register
  ipl_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_opcode   (in_tuser),
    .in_position (in_tdata[POS_W-1:0]),
    .in_coord    (in_tdata[POS_W+COORD_W-1:POS_W]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_ok      (res_ok),
    .out_coord   (res_coord),
    .out_count   (res_count)
  );

  // pack the result word, spare top bit held at zero
  assign out_tdata = {{(OUT_TDATA_W-COORD_W-COUNT_W){1'b0}}, res_count, res_coord};
  assign out_tuser = res_ok;

endmodule

`default_nettype wire

/* rtl/ipl_datapath.sv */
// datapath of the indexed position list: entry memory, count, move pointer,
// result register; depends on ipl_pkg and indexed_position_list_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_position_list_assert.svh"

module ipl_datapath import ipl_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ipl_cmd_t            cmd,
  output ipl_status_t              status,
  input  wire logic [OP_W-1:0]     in_opcode,
  input  wire logic [POS_W-1:0]    in_position,
  input  wire logic [COORD_W-1:0]  in_coord,
  input  wire logic                out_tready,
  output logic                     out_tvalid,
  output logic                     out_ok,
  output logic [COORD_W-1:0]       out_coord,
  output logic [COUNT_W-1:0]       out_count
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int MW  = (CW > POS_W) ? CW : POS_W;
  localparam int EW  = MW + 1;
  localparam int XVW = (VALUE_BITS > COORD_W) ? VALUE_BITS : COORD_W;

  logic [VALUE_BITS-1:0] mem [CAPACITY];

  ipl_op_t               op_r;
  logic [POS_W-1:0]      pos_r;
  logic [VALUE_BITS-1:0] coord_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  out_tvalid_r;
  logic                  out_ok_r;
  logic [COORD_W-1:0]    out_coord_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic [EW-1:0]         pos_e, cnt_e, ptr_e, rd_addr_e;
  logic                  ok_cond, shift_needed, shift_last;
  logic                  rd_en, wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic [COORD_W-1:0]    res_coord;

  assign pos_e = EW'(pos_r);
  assign cnt_e = EW'(count_r);
  assign ptr_e = EW'(ptr_r);

  always_comb begin
    ok_cond      = 1'b0;
    shift_needed = 1'b0;
    shift_last   = 1'b0;
    unique case (op_r)
      OP_READ: begin
        ok_cond = (pos_e < cnt_e);
      end
      OP_INSERT: begin
        ok_cond      = (pos_e <= cnt_e) && (cnt_e < EW'(CAPACITY));
        shift_needed = (pos_e != cnt_e);
        shift_last   = (ptr_e == pos_e + EW'(1));
      end
      OP_REMOVE: begin
        ok_cond      = (pos_e < cnt_e);
        shift_needed = (pos_e + EW'(1) != cnt_e);
        shift_last   = (ptr_e + EW'(2) == cnt_e);
      end
      OP_REPLACE: begin
        ok_cond = (pos_e < cnt_e);
      end
      OP_CLEAR: begin
        ok_cond = 1'b1;
      end
      default: begin
        ok_cond = 1'b0;
      end
    endcase
  end

  // read address and pointer for the entry move
  always_comb begin
    rd_en     = cmd.setup || cmd.step;
    rd_addr_e = pos_e;
    ptr_nxt   = ptr_r;
    if (cmd.setup) begin
      priority case (op_r)
        OP_INSERT: begin
          rd_addr_e = cnt_e - EW'(1);
          ptr_nxt   = count_r[AW-1:0];
        end
        OP_REMOVE: begin
          rd_addr_e = pos_e + EW'(1);
          ptr_nxt   = pos_r[AW-1:0];
        end
        default: begin
          rd_addr_e = pos_e;
        end
      endcase
    end else if (cmd.step) begin
      if (op_r == OP_INSERT) begin
        rd_addr_e = ptr_e - EW'(2);
        ptr_nxt   = ptr_r - AW'(1);
      end else begin
        rd_addr_e = ptr_e + EW'(2);
        ptr_nxt   = ptr_r + AW'(1);
      end
    end
  end

  always_comb begin
    wr_en   = cmd.step || cmd.write_item;
    wr_addr = cmd.step ? ptr_r : pos_e[AW-1:0];
    wr_data = cmd.step ? rd_data_r : coord_r;
  end

  always_comb begin
    count_nxt = count_r;
    if (ok_cond) begin
      priority case (op_r)
        OP_INSERT: count_nxt = count_r + CW'(1);
        OP_REMOVE: count_nxt = count_r - CW'(1);
        OP_CLEAR:  count_nxt = '0;
        default:   count_nxt = count_r;
      endcase
    end
  end

  always_comb begin
    res_coord = '0;
    if (ok_cond && (op_r == OP_READ)) begin
      res_coord = COORD_W'(XVW'(rd_data_r));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr_e[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= ipl_op_t'(in_opcode);
      pos_r   <= in_position;
      coord_r <= VALUE_BITS'(XVW'(in_coord));
    end
    if (cmd.setup || cmd.step) begin
      ptr_r <= ptr_nxt;
    end
    if (cmd.res_load) begin
      out_ok_r    <= ok_cond;
      out_coord_r <= res_coord;
      out_count_r <= COUNT_W'(EW'(count_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.res_load) begin
        count_r <= count_nxt;
      end
      if (cmd.res_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign status.op           = op_r;
  assign status.ok           = ok_cond;
  assign status.shift_needed = shift_needed;
  assign status.shift_last   = shift_last;
  assign status.out_free     = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_ok     = out_ok_r;
  assign out_coord  = out_coord_r;
  assign out_count  = out_count_r;

  `IPL_ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > CW'(CAPACITY), "count above capacity")
  `IPL_ASSERT(a_count_hold, clk, rst_n, !cmd.res_load |=> $stable(count_r), "count moved without result")
  `IPL_ASSERT(a_res_slot, clk, rst_n, cmd.res_load |-> (!out_tvalid_r || out_tready), "result overwrote pending word")
  `IPL_ASSERT_NEVER(a_wr_clash, clk, rst_n, cmd.step && cmd.write_item, "move and item write together")

endmodule

`default_nettype wire

/* rtl/ipl_controller.sv */
// sequencing state machine of the indexed position list
// depends on ipl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ipl_controller import ipl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire ipl_status_t status,
  output ipl_cmd_t         cmd
);

  ipl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (!status.ok) begin
          state_nxt = S_DONE;
        end else begin
          unique case (status.op)
            OP_READ:    state_nxt = S_PRIME;
            OP_INSERT:  state_nxt = status.shift_needed ? S_PRIME : S_WRITE;
            OP_REMOVE:  state_nxt = status.shift_needed ? S_PRIME : S_DONE;
            OP_REPLACE: state_nxt = S_WRITE;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_PRIME: begin
        state_nxt = (status.op == OP_READ) ? S_DONE : S_SHIFT;
      end
      S_SHIFT: begin
        if (status.shift_last) begin
          state_nxt = (status.op == OP_INSERT) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_PRIME:  cmd.setup      = 1'b1;
      S_SHIFT:  cmd.step       = 1'b1;
      S_WRITE:  cmd.write_item = 1'b1;
      S_DONE:   cmd.res_load   = status.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
// self-checking bench for the indexed position list: drives list edits over the
// input stream and checks every result word against a behavioural list model
// depends on ipl_pkg and indexed_position_list
`timescale 1ns / 1ps

module tb;
  import ipl_pkg::*;

  localparam int LIST_DEPTH   = CAPACITY_DEF;
  localparam int HOLD_CYCLES  = 400;              // long receiver hold-off
  localparam int DRAIN_CYCLES = LIST_DEPTH + 16;  // worst op plus margin
  localparam time RUN_LIMIT   = 20_000_000;       // ns, far above the slowest run

  // opcodes the block must reject
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic [COORD_W-1:0] COORD_ONES = '1;

  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] coord;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;   // position, coord_in, zero pad
  logic [OP_W-1:0]       in_tuser = '0;   // opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // coord_out, count, zero pad
  logic                  out_tuser;       // ok

  // shadow copy of the list, advanced as each word is accepted
  logic [COORD_W-1:0] shadow_words [LIST_DEPTH];
  int unsigned        shadow_len = 0;

  list_result_t expected_results [$];
  int           mismatch_count = 0;

  // idling controls shared between the test tasks and the two stream sides
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_requests = 0;
  int hold_served = 0;
  int rx_stall_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  indexed_position_list DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // gap length: mostly short, now and then medium, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // apply one list edit to the shadow list and return the result word it gives
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [COORD_W-1:0] coord);
    list_result_t res;
    res = '0;
    case (op)
      OP_READ: begin
        if (pos < shadow_len) begin
          res.coord = shadow_words[pos];
          res.ok    = 1'b1;
        end
      end
      OP_INSERT: begin
        // positions up to the current length are legal; refused when full
        if (pos <= shadow_len && shadow_len < LIST_DEPTH) begin
          for (int i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = coord;
          shadow_len++;
          res.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos < shadow_len) begin
          for (int i = pos; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
          res.ok = 1'b1;
        end
      end
      OP_REPLACE: begin
        if (pos < shadow_len) begin
          shadow_words[pos] = coord;
          res.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        shadow_len = 0;
        res.ok = 1'b1;
      end
      default: ;  // unused opcodes are refused and change nothing
    endcase
    res.count = shadow_len[COUNT_W-1:0];
    return res;
  endfunction

  // offer one word, optionally after an idle gap, and predict it once taken
  // tvalid is left high afterwards so back-to-back words need no toggle
  task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [COORD_W-1:0] coord);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, coord, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(apply_list_op(op, pos, coord));
  endtask

  // one random edit steered by the shadow length; grow_pct and shrink_pct set
  // how often inserts and removes come; the rest are mostly reads and replaces
  task automatic send_random_edit(input int grow_pct, input int shrink_pct);
    int r;
    int p;
    int c;
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   pos;
    logic [COORD_W-1:0] coord;
    r = $urandom_range(0, 99);
    if (r < grow_pct) op = OP_INSERT;
    else if (r < grow_pct + shrink_pct) op = OP_REMOVE;
    else if (r == 99) op = OP_CLEAR;
    else if (r == 98) op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    else if (r[0]) op = OP_READ;
    else op = OP_REPLACE;

    p = $urandom_range(0, 9);
    if (p == 0) begin
      pos = POS_W'($urandom_range(0, 127));        // noise over the whole field
    end else if (p == 1) begin
      // boundary positions around the current length and the capacity
      case ($urandom_range(0, 3))
        0: pos = POS_W'(shadow_len);
        1: pos = POS_W'(shadow_len + 1);
        2: pos = (shadow_len > 0) ? POS_W'(shadow_len - 1) : '0;
        default: pos = POS_W'(LIST_DEPTH);
      endcase
    end else if (op == OP_INSERT) begin
      pos = POS_W'($urandom_range(0, shadow_len));
    end else begin
      pos = (shadow_len > 0) ? POS_W'($urandom_range(0, shadow_len - 1)) : '0;
    end

    c = $urandom_range(0, 15);
    if (c == 0) coord = '0;
    else if (c == 1) coord = COORD_ONES;
    else coord = $urandom();
    send_word(op, pos, coord);
  endtask

  // receiver: random stalls, plus a long hold-off whenever a test asks for one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready    <= 1'b0;
      rx_stall_left  = 0;
    end else if (hold_requests != hold_served) begin
      hold_served    = hold_requests;
      rx_stall_left  = HOLD_CYCLES - 1;
      out_tready    <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      rx_stall_left  = pick_gap() - 1;
      out_tready    <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker: every word taken is matched against the oldest prediction
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: ok=%0b coord_out=%h count=%0d",
               out_tuser, out_tdata[31:0], out_tdata[38:32]);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[31:0] !== want.coord) begin
          $error("coord_out: expected %h, got %h", want.coord, out_tdata[31:0]);
          mismatch_count++;
        end
        if (out_tdata[38:32] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_tdata[38:32]);
          mismatch_count++;
        end
      end
    end
  end

  // edits on an empty list are refused, save an insert at the head and a clear
  task automatic test_empty_list_errors();
    send_word(OP_READ, 0, 32'h0000_0001);
    send_word(OP_REMOVE, 0, '0);
    send_word(OP_REPLACE, 0, COORD_ONES);
    send_word(OP_INSERT, 1, 32'h1111_1111);   // beyond the length
  endtask

  // head, tail and middle inserts, reads across the list, replace and removes
  task automatic test_edit_sequence();
    send_word(OP_INSERT, 0, COORD_ONES);
    send_word(OP_INSERT, 1, '0);               // append at the tail
    send_word(OP_INSERT, 0, 32'hA5A5_5A5A);    // new head
    send_word(OP_INSERT, 1, 32'h1234_5678);    // middle
    for (int i = 0; i < 4; i++) send_word(OP_READ, POS_W'(i), '0);
    send_word(OP_READ, 4, '0);                 // one past the end
    send_word(OP_READ, 127, '0);               // top of the position field
    send_word(OP_REPLACE, 3, 32'h8000_0001);
    send_word(OP_REMOVE, 1, '0);               // middle
    send_word(OP_REMOVE, 2, '0);               // tail
    send_word(OP_READ, 1, '0);
    send_word(OP_INSERT, 64, 32'h0F0F_0F0F);   // far beyond the length
  endtask

  // unused opcodes are refused; clear always succeeds
  task automatic test_unknown_and_clear();
    send_word(OP_UNUSED_LO, 0, COORD_ONES);
    send_word(OP_W'(OP_UNUSED_LO + 1), 1, COORD_ONES);
    send_word(OP_UNUSED_HI, 127, COORD_ONES);
    send_word(OP_CLEAR, 127, COORD_ONES);
    send_word(OP_READ, 0, '0);
    send_word(OP_CLEAR, 0, '0);                // clear of an empty list
  endtask

  // fill to capacity at random positions, then probe the full list
  task automatic test_fill_to_capacity();
    while (shadow_len < LIST_DEPTH)
      send_word(OP_INSERT, POS_W'($urandom_range(0, shadow_len)), $urandom());
    send_word(OP_INSERT, POS_W'(LIST_DEPTH), 32'h7777_7777);  // refused: full
    send_word(OP_INSERT, 0, 32'h7777_7777);                   // refused: full
    send_word(OP_READ, POS_W'(LIST_DEPTH - 1), '0);
    send_word(OP_READ, POS_W'(LIST_DEPTH), '0);
    send_word(OP_REPLACE, POS_W'(LIST_DEPTH - 1), COORD_ONES);
    send_word(OP_REMOVE, 0, '0);                              // longest shift down
    send_word(OP_INSERT, 0, 32'h0000_FFFF);                   // longest shift up
    send_word(OP_REMOVE, POS_W'(LIST_DEPTH - 1), '0);
    send_word(OP_READ, POS_W'(LIST_DEPTH - 2), '0);
  endtask

  // random edits with a given mix and idling
  task automatic test_random_edits(input int n, input int grow_pct, input int shrink_pct,
                                   input bit idle);
    tx_idle_on = idle;
    rx_idle_on = idle;
    repeat (n) send_random_edit(grow_pct, shrink_pct);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver holds off for a long stretch while words keep coming, so the
  // result register fills and the block stops taking input
  task automatic test_output_backpressure();
    hold_requests++;
    tx_idle_on = 1'b0;
    repeat (30) send_random_edit(35, 30);
    tx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list_errors();
    test_edit_sequence();
    test_unknown_and_clear();
    test_fill_to_capacity();
    test_random_edits(350, 60, 15, 1'b1);   // mostly growth, runs into full
    test_output_backpressure();
    test_random_edits(450, 35, 30, 1'b1);
    test_random_edits(150, 35, 30, 1'b0);   // a stretch with no idling
    test_random_edits(300, 15, 55, 1'b1);   // mostly shrinking, hits empty
    test_random_edits(80, 60, 15, 1'b0);

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule
